@@ design/nfa_pkg.sv @@
// ============================================================================
// nfa_pkg
// Shared types and constants for the NOR flash array with wear tracking:
// array geometry, request and status codes, and the request, response and
// word-memory port structs.
// ============================================================================
package nfa_pkg;

    // Array geometry
    localparam int TOTAL_WORDS     = 16384;
    localparam int SECTOR_WORDS    = 1024;
    localparam int NUM_SECTORS     = 16;
    localparam int PROG_UNIT_BYTES = 4;

    localparam int WADDR_W  = $clog2(TOTAL_WORDS);   // word address
    localparam int SECOFF_W = $clog2(SECTOR_WORDS);  // word offset in a sector
    localparam int SEC_W    = $clog2(NUM_SECTORS);   // sector index
    localparam int CNT_W    = 32;                    // wear count
    localparam int SUM_W    = CNT_W + SEC_W;         // wear count sum

    // A word access is four bytes at byte address 4*word_addr
    localparam bit ALIGN_OK = ((4 % PROG_UNIT_BYTES) == 0);

    // Request codes
    localparam logic [2:0] REQ_READ    = 3'd0;
    localparam logic [2:0] REQ_PROGRAM = 3'd1;
    localparam logic [2:0] REQ_ERASE   = 3'd2;
    localparam logic [2:0] REQ_SETBAD  = 3'd3;
    localparam logic [2:0] REQ_QUERY   = 3'd4;
    localparam logic [2:0] REQ_STATS   = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_IO      = 2'd2;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [13:0] word_addr;
        logic [31:0] write_data;
        logic [3:0]  sector;
        logic        mark_value;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_data;
        logic        is_bad;
        logic [31:0] wear_min;
        logic [31:0] wear_max;
        logic [31:0] wear_avg;
    } t_rsp;

    // Word memory port: one write and one registered read per cycle
    typedef struct packed {
        logic               rd_en;
        logic [WADDR_W-1:0] rd_addr;
        logic               wr_en;
        logic [WADDR_W-1:0] wr_addr;
        logic [31:0]        wr_data;
    } t_mem_req;

endpackage

@@ design/nfa_flash_mem.sv @@
// ============================================================================
// nfa_flash_mem
// Flash word array: single write port, single read port with registered
// read data that holds its value while no read is issued.
// ============================================================================
module nfa_flash_mem (
    input  logic            i_clk,
    input  nfa_pkg::t_mem_req i_req,
    output logic [31:0]     o_rdata
);
    import nfa_pkg::*;

    logic [31:0] r_mem [TOTAL_WORDS];
    logic [31:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // read port, data held between reads
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/nor_flash_array_with_wear_tracking.sv @@
// ============================================================================
// nor_flash_array_with_wear_tracking
// Word-programmable NOR flash array model with per-sector bad marks and
// saturating erase counts, plus wear statistics over all sectors.
// ============================================================================
//
//  Channel   Handshake                     Word
//  request   i_req_valid / o_req_ready     i_req (t_req)
//  response  o_rsp_valid / i_rsp_ready     o_rsp (t_rsp)
//  config    i_cfg_we                      i_cfg_wdata (erased byte)
//
//  Read, program, bad mark, bad query, unknown request: accept, then S_RD on the
//  registered word read or the finishing state S_FIN. Erase: accept, then S_ERASE
//  fills the sector one word per cycle on the single write port, then S_ERDONE; a
//  bad sector goes to S_FIN. Wear stats: S_STAT walks every count, then S_FIN.
//  After reset a clearing pass writes all TOTAL_WORDS words with o_req_ready low;
//  config writes are taken throughout. A full response register stalls the block.
//
module nor_flash_array_with_wear_tracking (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  nfa_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output nfa_pkg::t_rsp o_rsp,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_wdata
);
    import nfa_pkg::*;

    localparam logic [2:0] S_INIT    = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_RD      = 3'd2;
    localparam logic [2:0] S_ERASE   = 3'd3;
    localparam logic [2:0] S_ERDONE  = 3'd4;
    localparam logic [2:0] S_STAT    = 3'd5;
    localparam logic [2:0] S_FIN     = 3'd6;

    localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(NUM_SECTORS - 1);

    logic [2:0]              r_state, n_state;
    t_req                    r_req, n_req;
    logic [WADDR_W-1:0]      r_ptr, n_ptr;
    logic [SEC_W-1:0]        r_cidx, n_cidx;
    logic [CNT_W-1:0]        r_min, n_min;
    logic [CNT_W-1:0]        r_max, n_max;
    logic [SUM_W-1:0]        r_sum, n_sum;
    logic [NUM_SECTORS-1:0]  r_bad, n_bad;
    logic [NUM_SECTORS-1:0]  r_cvalid, n_cvalid;
    logic [7:0]              r_erased_byte;
    logic                    r_rsp_valid;
    t_rsp                    r_rsp;

    // wear count memory
    logic [CNT_W-1:0]        r_cnt_mem [NUM_SECTORS];
    logic [CNT_W-1:0]        r_cnt_rdata;
    logic                    r_cnt_rvld;
    logic                    cnt_re, cnt_we;
    logic [SEC_W-1:0]        cnt_raddr;
    logic [CNT_W-1:0]        cnt_wdata;
    logic [CNT_W-1:0]        cnt_cur;

    t_mem_req                mem_req;
    logic [31:0]             mem_rdata;

    logic                    accept;
    logic                    rsp_free;
    logic                    load_rsp;
    t_rsp                    rsp_next;
    logic [SEC_W-1:0]        wsec;
    logic                    wbad;

    nfa_flash_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    assign accept      = i_req_valid && o_req_ready;
    assign o_req_ready = (r_state == S_IDLE);
    assign rsp_free    = !r_rsp_valid || i_rsp_ready;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // unwritten counts read as zero
    assign cnt_cur = r_cnt_rvld ? r_cnt_rdata : '0;

    // sector holding the latched word address
    assign wsec = r_req.word_addr[WADDR_W-1 -: SEC_W];
    assign wbad = r_bad[wsec];

    // next-state and datapath
    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_ptr     = r_ptr;
        n_cidx    = r_cidx;
        n_min     = r_min;
        n_max     = r_max;
        n_sum     = r_sum;
        n_bad     = r_bad;
        n_cvalid  = r_cvalid;
        mem_req   = '0;
        cnt_re    = 1'b0;
        cnt_raddr = r_req.sector;
        cnt_we    = 1'b0;
        cnt_wdata = (&cnt_cur) ? cnt_cur : cnt_cur + CNT_W'(1);
        load_rsp  = 1'b0;
        rsp_next  = '0;

        unique case (r_state)
            // clearing pass: every word erased to all ones
            S_INIT: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = r_ptr;
                mem_req.wr_data = '1;
                n_ptr           = r_ptr + WADDR_W'(1);
                if (&r_ptr) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (accept) begin
                    n_req = i_req;
                    unique case (i_req.req_type)
                        REQ_READ, REQ_PROGRAM: begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = i_req.word_addr;
                            n_state         = S_RD;
                        end
                        REQ_ERASE: begin
                            if (r_bad[i_req.sector]) begin
                                n_state = S_FIN;
                            end else begin
                                cnt_re    = 1'b1;
                                cnt_raddr = i_req.sector;
                                n_ptr     = {i_req.sector, {SECOFF_W{1'b0}}};
                                n_state   = S_ERASE;
                            end
                        end
                        REQ_STATS: begin
                            cnt_re    = 1'b1;
                            cnt_raddr = '0;
                            n_cidx    = '0;
                            n_min     = '1;
                            n_max     = '0;
                            n_sum     = '0;
                            n_state   = S_STAT;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end

            // read or program on the word just fetched
            S_RD: begin
                if (rsp_free) begin
                    load_rsp = 1'b1;
                    n_state  = S_IDLE;
                    if (r_req.req_type == REQ_READ) begin
                        if (wbad) begin
                            rsp_next.status = ST_IO;
                        end else begin
                            rsp_next.read_data = mem_rdata;
                        end
                    end else begin
                        // range always holds: address width spans the array
                        priority if (!ALIGN_OK) begin
                            rsp_next.status = ST_INVALID;
                        end else if (wbad) begin
                            rsp_next.status = ST_IO;
                        end else if ((~mem_rdata & r_req.write_data) != '0) begin
                            rsp_next.status = ST_INVALID;
                        end else begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = r_req.word_addr;
                            mem_req.wr_data = mem_rdata & r_req.write_data;
                        end
                    end
                end
            end

            // sector fill, one word per cycle
            S_ERASE: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = r_ptr;
                mem_req.wr_data = {4{r_erased_byte}};
                n_ptr           = r_ptr + WADDR_W'(1);
                if (&r_ptr[SECOFF_W-1:0]) begin
                    n_state = S_ERDONE;
                end
            end

            // bump wear count (saturating) and report
            S_ERDONE: begin
                if (rsp_free) begin
                    cnt_we                  = 1'b1;
                    n_cvalid[r_req.sector]  = 1'b1;
                    load_rsp                = 1'b1;
                    n_state                 = S_IDLE;
                end
            end

            // walk the counts: min, max and sum
            S_STAT: begin
                if (cnt_cur < r_min) begin
                    n_min = cnt_cur;
                end
                if (cnt_cur > r_max) begin
                    n_max = cnt_cur;
                end
                n_sum = r_sum + SUM_W'(cnt_cur);
                if (r_cidx == SEC_LAST) begin
                    n_state = S_FIN;
                end else begin
                    cnt_re    = 1'b1;
                    cnt_raddr = r_cidx + SEC_W'(1);
                    n_cidx    = r_cidx + SEC_W'(1);
                end
            end

            // requests finished without the word memory
            S_FIN: begin
                if (rsp_free) begin
                    load_rsp = 1'b1;
                    n_state  = S_IDLE;
                    unique case (r_req.req_type)
                        REQ_ERASE: begin
                            rsp_next.status = ST_IO;
                        end
                        REQ_SETBAD: begin
                            n_bad[r_req.sector] = r_req.mark_value;
                        end
                        REQ_QUERY: begin
                            rsp_next.is_bad = r_bad[r_req.sector];
                        end
                        REQ_STATS: begin
                            rsp_next.wear_min = r_min;
                            rsp_next.wear_max = r_max;
                            rsp_next.wear_avg = r_sum[SUM_W-1:SEC_W];
                        end
                        default: begin
                            rsp_next.status = ST_INVALID;
                        end
                    endcase
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_INIT;
            r_ptr         <= '0;
            r_bad         <= '0;
            r_cvalid      <= '0;
            r_erased_byte <= 8'hFF;
            r_rsp_valid   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_bad    <= n_bad;
            r_cvalid <= n_cvalid;
            if (i_cfg_we) begin
                r_erased_byte <= i_cfg_wdata;
            end
            if (load_rsp) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_cidx <= n_cidx;
        r_min  <= n_min;
        r_max  <= n_max;
        r_sum  <= n_sum;
        if (load_rsp) begin
            r_rsp <= rsp_next;
        end
    end

    // wear count memory, registered read with valid flag
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[r_req.sector] <= cnt_wdata;
        end
        if (cnt_re) begin
            r_cnt_rdata <= r_cnt_mem[cnt_raddr];
            r_cnt_rvld  <= r_cvalid[cnt_raddr];
        end
    end

endmodule
